// File: design/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and helpers for the ray/plane intersection block
// Holds fixed-point widths, register indexes, the divider token and the
// saturation helpers used by the stages.
// ----------------------------------------------------------------------------
`default_nettype none
package rpi_pkg;

  localparam int QW        = 32;        // Q16.16 word width
  localparam int FRAC      = 16;        // fraction bits
  localparam int TOLW      = 16;        // tolerance width
  localparam int CFG_IDX_W = 3;
  localparam int DIVW      = QW + FRAC; // dividend and quotient width
  localparam int DIV_STEPS = DIVW;      // one quotient bit per cell

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_TOL    = 3'd4;

  localparam logic signed [QW-1:0] S32_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] S32_MIN = {1'b1, {(QW-1){1'b0}}};

  // One transaction as it travels through the divider chain.
  typedef struct packed {
    logic                  valid;
    logic [QW-1:0]         rem;
    logic [DIVW-1:0]       dq;      // dividend bits on top, quotient bits below
    logic [QW-1:0]         dmag;
    logic                  q_neg;
    logic                  den_zero;
    logic [2:0][QW-1:0]    org;
    logic [2:0][QW-1:0]    dir;
  } div_tok_t;

  // Saturate a 50 bit signed value to 32 bits.
  function automatic logic signed [QW-1:0] sat50(input logic signed [49:0] x);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'(S32_MAX);
    lo = 50'(S32_MIN);
    if (x > hi) return S32_MAX;
    else if (x < lo) return S32_MIN;
    else return x[QW-1:0];
  endfunction

  // Saturate a 34 bit signed value to 32 bits.
  function automatic logic signed [QW-1:0] sat34(input logic signed [33:0] x);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'(S32_MAX);
    lo = 34'(S32_MIN);
    if (x > hi) return S32_MAX;
    else if (x < lo) return S32_MIN;
    else return x[QW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/rpi_div_cell.sv
// ----------------------------------------------------------------------------
// rpi_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and records the quotient bit, then hands the token onward.
// ----------------------------------------------------------------------------
`default_nettype none
module rpi_div_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  rpi_pkg::div_tok_t       tok_i,
  output rpi_pkg::div_tok_t       tok_o
);
  import rpi_pkg::*;

  div_tok_t         tok_r;
  div_tok_t         tok_nxt;
  logic [QW:0]      shifted;
  logic [QW:0]      diff;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    shifted = {tok_i.rem, tok_i.dq[DIVW-1]};
    diff    = shifted - {1'b0, tok_i.dmag};
    tok_nxt = tok_i;
    if (!diff[QW]) begin
      tok_nxt.rem = diff[QW-1:0];
      tok_nxt.dq  = {tok_i.dq[DIVW-2:0], 1'b1};
    end else begin
      tok_nxt.rem = shifted[QW-1:0];
      tok_nxt.dq  = {tok_i.dq[DIVW-2:0], 1'b0};
    end
  end

  // Token register; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// File: design/rpi_divider.sv
// ----------------------------------------------------------------------------
// rpi_divider: chain of division cells
// Each cell resolves one quotient bit, so a new transaction enters every
// cycle while en is high and leaves after passing through DIV_STEPS cells.
// ----------------------------------------------------------------------------
`default_nettype none
module rpi_divider (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  rpi_pkg::div_tok_t       tok_i,
  output rpi_pkg::div_tok_t       tok_o
);
  import rpi_pkg::*;

  div_tok_t link [DIV_STEPS+1];

  assign link[0] = tok_i;

  // One cell per quotient bit.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    rpi_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  assign tok_o = link[DIV_STEPS];

endmodule
`default_nettype wire

// File: design/ray_plane_intersect.sv
// Pipeline: 54 register stages from an accepted input transaction to out_valid:
// three before the divider, 48 divider cells, two after it and the output register.
// Throughput: one ray per cycle while in_stall is low; the divider is a chain of one-bit cells.
// A skid entry behind the output register takes one result when the output
// stalls; while it is full, in_stall is high and the whole pipeline holds.
// Reset (synchronous, rst_n low) clears all valid bits and loads the plane
// registers with normal (0,0,1), offset 0 and start tolerance 7.
// ----------------------------------------------------------------------------
// ray_plane_intersect: ray/plane intersection in Q16.16
// Computes t = (-(n.o) - offset) / (n.v) and the hit point o + v*t.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_plane_intersect (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire  [rpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rpi_pkg::QW-1:0]          cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [rpi_pkg::QW-1:0]   in_origin_x,
  input  wire  signed [rpi_pkg::QW-1:0]   in_origin_y,
  input  wire  signed [rpi_pkg::QW-1:0]   in_origin_z,
  input  wire  signed [rpi_pkg::QW-1:0]   in_dir_x,
  input  wire  signed [rpi_pkg::QW-1:0]   in_dir_y,
  input  wire  signed [rpi_pkg::QW-1:0]   in_dir_z,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_hit,
  output logic signed [rpi_pkg::QW-1:0]   out_hit_x,
  output logic signed [rpi_pkg::QW-1:0]   out_hit_y,
  output logic signed [rpi_pkg::QW-1:0]   out_hit_z
);
  import rpi_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [2:0][QW-1:0] pt;
  } res_t;

  // Configuration registers.
  logic signed [QW-1:0] nx_r, ny_r, nz_r, off_r;
  logic [TOLW-1:0]      tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= QW'(32'sd65536);
      off_r <= '0;
      tol_r <= TOLW'(7);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_NORMAL_X:     nx_r  <= cfg_data;
        REG_NORMAL_Y:     ny_r  <= cfg_data;
        REG_NORMAL_Z:     nz_r  <= cfg_data;
        REG_PLANE_OFFSET: off_r <= cfg_data;
        REG_START_TOL:    tol_r <= cfg_data[TOLW-1:0];
        default: ;
      endcase
    end
  end

  logic skid_v_r;
  logic en;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Stage 1: the six products of the two dot products.
  logic                       s1_v_r;
  logic signed [2*QW-1:0]     s1_pv_r [3];
  logic signed [2*QW-1:0]     s1_po_r [3];
  logic [2:0][QW-1:0]         s1_org_r, s1_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r     <= in_valid;
      s1_pv_r[0] <= nx_r * in_dir_x;
      s1_pv_r[1] <= ny_r * in_dir_y;
      s1_pv_r[2] <= nz_r * in_dir_z;
      s1_po_r[0] <= nx_r * in_origin_x;
      s1_po_r[1] <= ny_r * in_origin_y;
      s1_po_r[2] <= nz_r * in_origin_z;
      s1_org_r   <= {in_origin_z, in_origin_y, in_origin_x};
      s1_dir_r   <= {in_dir_z, in_dir_y, in_dir_x};
    end
  end

  // Stage 2: exact sums floored to Q16.16; the denominator is saturated,
  // n.o stays wide so the numerator saturates only once.
  logic signed [2*QW+1:0] sum_v, sum_o;
  logic signed [QW-1:0]   s2_den_r;
  logic signed [49:0]     s2_no_r;
  logic                   s2_v_r;
  logic [2:0][QW-1:0]     s2_org_r, s2_dir_r;

  always_comb begin
    sum_v = 66'(s1_pv_r[0]) + 66'(s1_pv_r[1]) + 66'(s1_pv_r[2]);
    sum_o = 66'(s1_po_r[0]) + 66'(s1_po_r[1]) + 66'(s1_po_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r   <= s1_v_r;
      s2_den_r <= sat50(50'(sum_v >>> FRAC));
      s2_no_r  <= 50'(sum_o >>> FRAC);
      s2_org_r <= s1_org_r;
      s2_dir_r <= s1_dir_r;
    end
  end

  // Stage 3: numerator and sign/magnitude form for the divider.
  logic signed [QW-1:0] num;
  logic [QW-1:0]        num_mag, den_mag;
  div_tok_t             s3_r;
  div_tok_t             div_out;

  always_comb begin
    num     = sat50(-s2_no_r - 50'(off_r));
    num_mag = num[QW-1] ? QW'(-num) : num;
    den_mag = s2_den_r[QW-1] ? QW'(-s2_den_r) : s2_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r.valid    <= s2_v_r;
      s3_r.rem      <= '0;
      s3_r.dq       <= {num_mag, {FRAC{1'b0}}};
      s3_r.dmag     <= den_mag;
      s3_r.q_neg    <= num[QW-1] ^ s2_den_r[QW-1];
      s3_r.den_zero <= (s2_den_r == '0);
      s3_r.org      <= s2_org_r;
      s3_r.dir      <= s2_dir_r;
    end
  end

  rpi_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tok_i (s3_r),
    .tok_o (div_out)
  );

  // Stage 4: signed, saturated t and the early miss decision.
  logic signed [QW-1:0] t_val;
  logic                 t_miss;
  logic signed [QW-1:0] s4_t_r;
  logic                 s4_v_r, s4_miss_r;
  logic [2:0][QW-1:0]   s4_org_r, s4_dir_r;

  always_comb begin
    t_miss = div_out.den_zero;
    if (!div_out.q_neg) begin
      t_val = (div_out.dq > DIVW'(S32_MAX)) ? S32_MAX : div_out.dq[QW-1:0];
    end else begin
      t_val = (div_out.dq > {{(DIVW-QW){1'b0}}, S32_MIN}) ? S32_MIN
            : QW'(-div_out.dq[QW-1:0]);
      if (div_out.dq != '0) t_miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r    <= div_out.valid;
      s4_t_r    <= t_val;
      s4_miss_r <= t_miss;
      s4_org_r  <= div_out.org;
      s4_dir_r  <= div_out.dir;
    end
  end

  // Stage 5: direction times t.
  logic signed [2*QW-1:0] s5_p_r [3];
  logic                   s5_v_r, s5_miss_r;
  logic [2:0][QW-1:0]     s5_org_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r    <= s4_v_r;
      s5_miss_r <= s4_miss_r;
      s5_org_r  <= s4_org_r;
      for (int i = 0; i < 3; i++) begin
        s5_p_r[i] <= $signed(s4_dir_r[i]) * s4_t_r;
      end
    end
  end

  // Hit point, start-point check and the final result.
  logic signed [QW-1:0] hp [3];
  logic signed [QW:0]   dlt [3];
  logic [QW:0]          dabs [3];
  logic                 near;
  res_t                 res;

  always_comb begin
    near = 1'b1;
    for (int i = 0; i < 3; i++) begin
      hp[i]   = sat50(50'($signed(s5_org_r[i])) + 50'(s5_p_r[i] >>> FRAC));
      dlt[i]  = 33'(hp[i]) - 33'($signed(s5_org_r[i]));
      dabs[i] = dlt[i][QW] ? 33'(-dlt[i]) : dlt[i];
      if (dabs[i] > 33'(tol_r)) near = 1'b0;
    end
    if (s5_miss_r || near) begin
      res = '0;
    end else begin
      res.hit = 1'b1;
      res.pt  = {hp[2], hp[1], hp[0]};
    end
  end

  // Output register with a skid entry behind it.
  res_t out_r, skid_r;
  logic out_v_r;
  logic out_free;
  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (s5_v_r) begin
      if (out_free) begin
        out_r   <= res;
        out_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (out_free) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_hit   = out_r.hit;
  assign out_hit_x = out_r.pt[0];
  assign out_hit_y = out_r.pt[1];
  assign out_hit_z = out_r.pt[2];

endmodule
`default_nettype wire

// File: tb/ray_plane_intersect_checker.sv
// ----------------------------------------------------------------------------
// Ray/plane intersection checker
// Watches the configuration port and both channels, predicts the result of
// every accepted ray from its own copy of the plane registers, and compares
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_plane_intersect_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_wr_en,
  input  wire  [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [rpi_pkg::QW-1:0]        cfg_data,
  input  wire                           in_valid,
  input  wire                           in_stall,
  input  wire  signed [31:0]            in_origin_x,
  input  wire  signed [31:0]            in_origin_y,
  input  wire  signed [31:0]            in_origin_z,
  input  wire  signed [31:0]            in_dir_x,
  input  wire  signed [31:0]            in_dir_y,
  input  wire  signed [31:0]            in_dir_z,
  input  wire                           out_valid,
  input  wire                           out_stall,
  input  wire                           out_hit,
  input  wire  signed [31:0]            out_hit_x,
  input  wire  signed [31:0]            out_hit_y,
  input  wire  signed [31:0]            out_hit_z,
  output int                            fail_count,
  output int                            pending
);
  import rpi_pkg::*;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } hit_rec_t;

  hit_rec_t expected_hits[$];

  logic signed [31:0] pl_nx, pl_ny, pl_nz, pl_off;
  logic [15:0]        pl_tol;

  // Clamp a wide signed value into the signed 32 bit range.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Floor of the exact three-term sum divided by 2^16; arithmetic shift floors.
  function automatic logic signed [127:0] dot_floor(
      input logic signed [31:0] a0, a1, a2, b0, b1, b2);
    logic signed [127:0] s;
    s = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2);
    return s >>> 16;
  endfunction

  function automatic hit_rec_t intersect_ray(
      input logic signed [31:0] ox, oy, oz, vx, vy, vz);
    hit_rec_t r;
    logic signed [31:0] den, num, t;
    logic signed [127:0] q, d;
    logic signed [31:0] o[3], v[3], h[3];
    logic near;
    r = '0;
    o[0] = ox; o[1] = oy; o[2] = oz;
    v[0] = vx; v[1] = vy; v[2] = vz;
    den = clamp32(dot_floor(pl_nx, pl_ny, pl_nz, vx, vy, vz));
    if (den == 0) return r;
    num = clamp32(-dot_floor(pl_nx, pl_ny, pl_nz, ox, oy, oz) - 128'(pl_off));
    // Signed division of SystemVerilog truncates toward zero.
    q = (128'(num) * 128'sd65536) / 128'(den);
    t = clamp32(q);
    if (t < 0) return r;
    near = 1'b1;
    for (int i = 0; i < 3; i++) begin
      h[i] = clamp32(128'(o[i]) + ((128'(v[i]) * 128'(t)) >>> 16));
      d = 128'(h[i]) - 128'(o[i]);
      if (d < 0) d = -d;
      if (d > 128'(pl_tol)) near = 1'b0;
    end
    if (near) return r;
    r.hit = 1'b1; r.x = h[0]; r.y = h[1]; r.z = h[2];
    return r;
  endfunction

  assign pending = expected_hits.size();

  // Track configuration, predict on input transactions, check output ones.
  always @(posedge clk) begin
    hit_rec_t e;
    if (!rst_n) begin
      pl_nx <= 0; pl_ny <= 0; pl_nz <= 32'sd65536; pl_off <= 0; pl_tol <= 16'd7;
      expected_hits.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_NORMAL_X:     pl_nx <= cfg_data;
          REG_NORMAL_Y:     pl_ny <= cfg_data;
          REG_NORMAL_Z:     pl_nz <= cfg_data;
          REG_PLANE_OFFSET: pl_off <= cfg_data;
          REG_START_TOL:    pl_tol <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_hits.push_back(intersect_ray(in_origin_x, in_origin_y, in_origin_z,
                                              in_dir_x, in_dir_y, in_dir_z));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result hit=%0d (%0d,%0d,%0d)", $time,
                   out_hit, out_hit_x, out_hit_y, out_hit_z);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_hits.pop_front();
          if (e.hit !== out_hit || e.x !== out_hit_x || e.y !== out_hit_y ||
              e.z !== out_hit_z) begin
            $display("%0t: expected hit=%0d (%0d,%0d,%0d) actual hit=%0d (%0d,%0d,%0d)",
                     $time, e.hit, e.x, e.y, e.z, out_hit, out_hit_x, out_hit_y,
                     out_hit_z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/ray_plane_intersect_test.sv
// ----------------------------------------------------------------------------
// Ray/plane intersection testbench
// Programs several planes, including extreme ones, and sends directed and
// random rays with random idle bursts on both channels; the checker compares.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_plane_intersect_test;
  import rpi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic signed [31:0] in_ox = 0, in_oy = 0, in_oz = 0, in_vx = 0, in_vy = 0, in_vz = 0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid, out_hit;
  wire signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  int fail_count, pending;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_plane_intersect uut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .in_origin_x(in_ox), .in_origin_y(in_oy), .in_origin_z(in_oz),
    .in_dir_x(in_vx), .in_dir_y(in_vy), .in_dir_z(in_vz),
    .out_valid, .out_stall, .out_hit, .out_hit_x, .out_hit_y, .out_hit_z
  );

  ray_plane_intersect_checker chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .in_origin_x(in_ox), .in_origin_y(in_oy), .in_origin_z(in_oz),
    .in_dir_x(in_vx), .in_dir_y(in_vy), .in_dir_z(in_vz),
    .out_valid, .out_stall, .out_hit, .out_hit_x, .out_hit_y, .out_hit_z,
    .fail_count, .pending
  );

  // Receiver stalls in random bursts until the quiet tail of the run.
  always @(posedge clk) begin
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // Mixed-magnitude random word: small values give meaningful hits.
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_plane(input logic [31:0] nx, ny, nz, off, input logic [15:0] tol);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_OFFSET, off);
    write_reg(REG_START_TOL, {16'h0, tol});
    cfg_wr_en <= 1'b0;
  endtask

  // Send one ray transaction, with an optional idle burst first.
  task automatic send_ray(input logic signed [31:0] ox, oy, oz, vx, vy, vz);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ox <= ox; in_oy <= oy; in_oz <= oz; in_vx <= vx; in_vy <= vy; in_vz <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_rays(input int count);
    for (int i = 0; i < count; i++)
      send_ray(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays on the reset plane z = 0.
    send_ray(0, 0, 32'sh00050000, 0, 0, -32'sh00010000);             // plain hit
    send_ray(0, 0, 32'sh00050000, 32'sh00010000, 0, 0);              // zero denominator
    send_ray(0, 0, 32'sh00050000, 0, 0, 32'sh00010000);              // negative t
    send_ray(3, 4, 0, 0, 0, -32'sh00010000);                         // hits its own start
    send_ray(0, 0, 8, 0, 0, -32'sh00010000);                         // just beyond tolerance
    send_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh7fffffff, 32'sh80000000, 32'sh80000000);           // extremes
    send_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh80000000, 32'sh7fffffff, 32'sh00000001);           // saturated t
    send_ray(-1, -1, -32'sh00010000, -1, -1, 32'sh00000001);         // tiny direction
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'sh12345678, -32'sh0abcdef0, 32'sh00300000, 32'sh00008000,
             -32'sh00004000, -32'sh00020000);
    drain();

    // A series of planes, extremes among them, each with random rays.
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
    random_rays(200);
    drain();
    set_plane(32'h00010000, 32'h00010000, 32'h00010000, 32'hfffd0000, 16'h0000);
    send_ray(32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 0, 32'sh00010000);
    random_rays(400);
    drain();
    set_plane(32'hffffffff, 32'h00000001, 32'h80000000, 32'h7fffffff, 16'h0001);
    random_rays(200);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_plane(rand_word(), rand_word(), rand_word(), rand_word(), 16'($urandom()));
      random_rays(250);
      drain();
    end
    // Final stretch without idling on either side.
    quiet = 1'b1;
    set_plane(0, 32'h00010000, 0, 32'hffec0000, 16'd7);
    random_rays(200);
    drain();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
